// ----- design/psrl_pkg.sv -----
// Shared types and constants of the per-source rate limiter.
package psrl_pkg;

  // Tracker table geometry.
  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned TOT_W         = $clog2(TABLE_ENTRIES + 1);

  // Field widths.
  localparam int unsigned LIMIT_W = 20;
  localparam int unsigned CNT_W   = 21;
  localparam int unsigned IP_W    = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned OUT_W   = 9;

  // Time limits in milliseconds and the count ceiling.
  localparam logic [TIME_W-1:0] WINDOW_MS = TIME_W'(1000);
  localparam logic [TIME_W-1:0] STALE_MS  = TIME_W'(2000);
  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};

  // Operation codes.
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_SWEEP = 1'b1;

  // Input word.
  typedef struct packed {
    logic              opcode;
    logic [IP_W-1:0]   source_ip;
    logic [TIME_W-1:0] now_ms;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic             allowed;
    logic             table_full_reject;
    logic [OUT_W-1:0] entries_in_use;
    logic [OUT_W-1:0] entries_removed;
  } out_word_t;

  // One tracker entry as it lies in the table memory.
  typedef struct packed {
    logic [IP_W-1:0]   source;
    logic [TIME_W-1:0] win_begin;
    logic [CNT_W-1:0]  count;
  } tracker_t;

  localparam int unsigned TRACKER_W = $bits(tracker_t);

endpackage

// ----- design/psrl_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with a registered read.
module psrl_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- design/per_source_rate_limiter_unit.sv -----
// Top level of the per-source fixed-window rate limiter.
//
// Usage: an input word on in_word_i (valid/ready) either checks one packet
// from a source address or sweeps stale trackers; each word yields exactly
// one result word on out_word_o (valid/ready). The user must write rate_limit
// through cfg_we_i / cfg_data_i only while the block is idle; the block itself
// does not enforce this. Zero turns limiting off. Trackers sit in a 256-entry
// synchronous RAM that is walked one entry per cycle through its single read
// port, so the length of the walk depends on the word: a check with limiting
// off skips the walk, a check of a known source stops at its entry, and a
// check of a new source, a check on a full table and a sweep walk all entries.
// One word is processed at a time; a new word is taken as soon as the
// previous result has been parked in the output register, so a stalled
// receiver holds up the next word only while that register is still full.
// Reset clears all tracker valid bits, the in-use total and rate_limit at
// once; the RAM contents are left as they are and need no clearing pass.
module per_source_rate_limiter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  psrl_pkg::in_word_t              in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output psrl_pkg::out_word_t             out_word_o,
  input  logic                            cfg_we_i,
  input  logic [psrl_pkg::LIMIT_W-1:0]    cfg_data_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [psrl_pkg::IDX_W-1:0] LAST_IDX =
    psrl_pkg::IDX_W'(psrl_pkg::TABLE_ENTRIES - 1);

  logic [1:0] state_q, state_d;

  logic [psrl_pkg::LIMIT_W-1:0]       rate_limit_q;
  logic [psrl_pkg::TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [psrl_pkg::TOT_W-1:0]         total_q, total_d;

  psrl_pkg::in_word_t  req_q, req_d;
  psrl_pkg::out_word_t res_q, res_d;
  psrl_pkg::out_word_t out_q, out_d;
  logic                out_valid_q, out_valid_d;

  // Table walk.
  logic [psrl_pkg::IDX_W:0]   scan_idx_q, scan_idx_d;
  logic [psrl_pkg::IDX_W-1:0] chk_idx_q, chk_idx_d;
  logic                       chk_vld_q, chk_vld_d;
  logic                       issue;

  // Lookup results.
  logic                       found_q, found_d;
  logic [psrl_pkg::IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic                       have_free_q, have_free_d;
  logic [psrl_pkg::IDX_W-1:0] free_idx_q, free_idx_d;
  psrl_pkg::tracker_t         hold_q, hold_d;
  logic [psrl_pkg::TOT_W-1:0] removed_q, removed_d;

  // RAM ports.
  logic                       ram_we;
  logic [psrl_pkg::IDX_W-1:0] ram_waddr;
  psrl_pkg::tracker_t         ram_wdata;
  psrl_pkg::tracker_t         ram_rdata;
  logic [psrl_pkg::TRACKER_W-1:0] ram_rdata_raw;

  // Scratch values for the evaluation of one entry and the update.
  logic                        entry_valid;
  logic [psrl_pkg::TIME_W-1:0] entry_age;
  logic [psrl_pkg::TIME_W-1:0] hit_age;
  logic [psrl_pkg::CNT_W-1:0]  base_cnt;
  logic [psrl_pkg::CNT_W-1:0]  new_cnt;
  logic [psrl_pkg::TIME_W-1:0] new_start;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign issue = (state_q == S_SCAN) && !scan_idx_q[psrl_pkg::IDX_W];

  // Tracker memory.
  psrl_ram #(
    .DEPTH (psrl_pkg::TABLE_ENTRIES),
    .WIDTH (psrl_pkg::TRACKER_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_idx_q[psrl_pkg::IDX_W-1:0]),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = psrl_pkg::tracker_t'(ram_rdata_raw);

  assign entry_valid = valid_q[chk_idx_q];
  assign entry_age   = req_q.now_ms - ram_rdata.win_begin;
  assign hit_age     = req_q.now_ms - hold_q.win_begin;

  // Window restart and saturating count for a found tracker.
  always_comb begin
    if (hit_age >= psrl_pkg::WINDOW_MS) begin
      base_cnt  = '0;
      new_start = req_q.now_ms;
    end else begin
      base_cnt  = hold_q.count;
      new_start = hold_q.win_begin;
    end
    new_cnt = (base_cnt == psrl_pkg::COUNT_MAX) ? base_cnt
                                                : base_cnt + psrl_pkg::CNT_W'(1);
  end

  // Main sequencer.
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    total_d     = total_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    scan_idx_d  = scan_idx_q;
    chk_idx_d   = scan_idx_q[psrl_pkg::IDX_W-1:0];
    chk_vld_d   = issue;
    found_d     = found_q;
    hit_idx_d   = hit_idx_q;
    have_free_d = have_free_q;
    free_idx_d  = free_idx_q;
    hold_d      = hold_q;
    removed_d   = removed_q;
    ram_we      = 1'b0;
    ram_waddr   = hit_idx_q;
    ram_wdata   = hold_q;

    // The output register frees up when the receiver takes its word.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (issue) begin
      scan_idx_d = scan_idx_q + (psrl_pkg::IDX_W + 1)'(1);
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d       = in_word_i;
          scan_idx_d  = '0;
          found_d     = 1'b0;
          have_free_d = 1'b0;
          removed_d   = '0;
          res_d       = '0;
          if (in_word_i.opcode == psrl_pkg::OP_CHECK && rate_limit_q == '0) begin
            res_d.allowed        = 1'b1;
            res_d.entries_in_use = psrl_pkg::OUT_W'(total_q);
            state_d              = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (chk_vld_q) begin
          if (req_q.opcode == psrl_pkg::OP_SWEEP) begin
            // Free every tracker whose window began too long ago.
            if (entry_valid && entry_age > psrl_pkg::STALE_MS) begin
              valid_d[chk_idx_q] = 1'b0;
              removed_d          = removed_q + psrl_pkg::TOT_W'(1);
            end
            if (chk_idx_q == LAST_IDX) begin
              total_d               = total_q - removed_d;
              res_d.entries_in_use  = psrl_pkg::OUT_W'(total_d);
              res_d.entries_removed = psrl_pkg::OUT_W'(removed_d);
              state_d               = S_DONE;
            end
          end else begin
            // Look for the source and remember the lowest free entry.
            if (!entry_valid && !have_free_q) begin
              have_free_d = 1'b1;
              free_idx_d  = chk_idx_q;
            end
            if (entry_valid && ram_rdata.source == req_q.source_ip) begin
              found_d   = 1'b1;
              hit_idx_d = chk_idx_q;
              hold_d    = ram_rdata;
              state_d   = S_UPD;
            end else if (chk_idx_q == LAST_IDX) begin
              state_d = S_UPD;
            end
          end
        end
      end

      S_UPD: begin
        // Write back the found tracker or create one in a free entry, and form the decision.
        if (found_q) begin
          ram_we             = 1'b1;
          ram_waddr          = hit_idx_q;
          ram_wdata.source       = hold_q.source;
          ram_wdata.win_begin    = new_start;
          ram_wdata.count        = new_cnt;
          res_d.allowed      = (new_cnt <= psrl_pkg::CNT_W'(rate_limit_q));
        end else if (have_free_q) begin
          ram_we                 = 1'b1;
          ram_waddr              = free_idx_q;
          ram_wdata.source       = req_q.source_ip;
          ram_wdata.win_begin    = req_q.now_ms;
          ram_wdata.count        = psrl_pkg::CNT_W'(1);
          valid_d[free_idx_q]    = 1'b1;
          total_d                = total_q + psrl_pkg::TOT_W'(1);
          res_d.allowed          = 1'b1;
        end else begin
          res_d.table_full_reject = 1'b1;
        end
        res_d.entries_in_use = psrl_pkg::OUT_W'(total_d);
        state_d              = S_DONE;
      end

      S_DONE: begin
        // Park the result once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rate_limit_q <= '0;
      valid_q      <= '0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
      scan_idx_q   <= '0;
      chk_vld_q    <= 1'b0;
      found_q      <= 1'b0;
      have_free_q  <= 1'b0;
      removed_q    <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      scan_idx_q  <= scan_idx_d;
      chk_vld_q   <= chk_vld_d;
      found_q     <= found_d;
      have_free_q <= have_free_d;
      removed_q   <= removed_d;
      if (cfg_we_i) begin
        rate_limit_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    out_q      <= out_d;
    chk_idx_q  <= chk_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    hold_q     <= hold_d;
  end

endmodule

// ----- sim/per_source_rate_limiter_unit_tb.sv -----
// Self-checking testbench for the per-source rate limiter with its own tracker-table predictor.
`timescale 1ns / 1ps

module per_source_rate_limiter_unit_tb;

  localparam logic [psrl_pkg::LIMIT_W-1:0] LIMIT_MAX = {psrl_pkg::LIMIT_W{1'b1}};
  localparam int unsigned        STALL_LIMIT    = 20000;
  localparam int unsigned        TAIL_CYCLES    = 300;
  localparam int unsigned        HOLD_OFF       = 1500;
  localparam int unsigned        POOL_SIZE      = 6;

  // Clock, reset and block ports.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  psrl_pkg::in_word_t  in_word_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  psrl_pkg::out_word_t out_word_o;
  logic                          cfg_we_i   = 1'b0;
  logic [psrl_pkg::LIMIT_W-1:0]  cfg_data_i = '0;

  per_source_rate_limiter_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Tracker table as the predictor sees it.
  bit                           trk_valid  [psrl_pkg::TABLE_ENTRIES];
  logic [psrl_pkg::IP_W-1:0]    trk_source [psrl_pkg::TABLE_ENTRIES];
  logic [psrl_pkg::TIME_W-1:0]  trk_window [psrl_pkg::TABLE_ENTRIES];
  logic [psrl_pkg::CNT_W-1:0]   trk_count  [psrl_pkg::TABLE_ENTRIES];
  int unsigned                  trk_live   = 0;
  logic [psrl_pkg::LIMIT_W-1:0] limit_now  = '0;

  // Results still owed by the block, oldest first.
  psrl_pkg::out_word_t pending_results[$];

  // Stimulus knobs shared with the receiver process.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;
  logic [psrl_pkg::TIME_W-1:0] cur_ms = '0;

  // Bookkeeping for the run summary.
  int unsigned err_count    = 0;
  int unsigned stall_cycles = 0;
  int unsigned n_words      = 0;
  int unsigned n_sweeps     = 0;
  int unsigned n_allowed    = 0;
  int unsigned n_limited    = 0;
  int unsigned n_full       = 0;
  int unsigned n_removed    = 0;
  int unsigned n_cfg        = 0;
  int unsigned peak_live    = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Work out the result of one word and advance the tracker table.
  function automatic psrl_pkg::out_word_t predict_result(input psrl_pkg::in_word_t w);
    psrl_pkg::out_word_t         r;
    int                          hit;
    int                          free_slot;
    bit                          found;
    bit                          have_free;
    logic [psrl_pkg::TIME_W-1:0] elapsed;
    int unsigned                 removed;
    r         = '0;
    hit       = 0;
    free_slot = 0;
    found     = 1'b0;
    have_free = 1'b0;
    removed   = 0;
    n_words++;
    if (w.opcode == psrl_pkg::OP_SWEEP) begin
      n_sweeps++;
      for (int i = 0; i < psrl_pkg::TABLE_ENTRIES; i++) begin
        elapsed = w.now_ms - trk_window[i];
        if (trk_valid[i] && elapsed > psrl_pkg::STALE_MS) begin
          trk_valid[i] = 1'b0;
          removed++;
        end
      end
      trk_live -= removed;
      n_removed += removed;
    end else if (limit_now == '0) begin
      // Limiting off: everything passes and no tracker is touched.
      r.allowed = 1'b1;
    end else begin
      for (int i = 0; i < psrl_pkg::TABLE_ENTRIES; i++) begin
        if (trk_valid[i]) begin
          if (!found && trk_source[i] == w.source_ip) begin
            found = 1'b1;
            hit   = i;
          end
        end else if (!have_free) begin
          have_free = 1'b1;
          free_slot = i;
        end
      end
      if (!found && !have_free) begin
        r.table_full_reject = 1'b1;
      end else begin
        if (!found) begin
          hit             = free_slot;
          trk_valid[hit]  = 1'b1;
          trk_source[hit] = w.source_ip;
          trk_window[hit] = w.now_ms;
          trk_count[hit]  = '0;
          trk_live++;
        end else begin
          elapsed = w.now_ms - trk_window[hit];
          if (elapsed >= psrl_pkg::WINDOW_MS) begin
            trk_window[hit] = w.now_ms;
            trk_count[hit]  = '0;
          end
        end
        if (trk_count[hit] < psrl_pkg::COUNT_MAX) trk_count[hit]++;
        r.allowed = (trk_count[hit] <= limit_now);
      end
    end
    if (w.opcode == psrl_pkg::OP_CHECK) begin
      if (r.table_full_reject) n_full++;
      else if (r.allowed) n_allowed++;
      else n_limited++;
    end
    if (trk_live > peak_live) peak_live = trk_live;
    r.entries_in_use  = psrl_pkg::OUT_W'(trk_live);
    r.entries_removed = psrl_pkg::OUT_W'(removed);
    return r;
  endfunction

  function automatic psrl_pkg::in_word_t make_word(input logic op,
                                                   input logic [psrl_pkg::IP_W-1:0] ip,
                                                   input logic [psrl_pkg::TIME_W-1:0] ms);
    psrl_pkg::in_word_t w;
    w.opcode    = op;
    w.source_ip = ip;
    w.now_ms    = ms;
    return w;
  endfunction

  function automatic bit ip_tracked(input logic [psrl_pkg::IP_W-1:0] ip);
    for (int i = 0; i < psrl_pkg::TABLE_ENTRIES; i++) begin
      if (trk_valid[i] && trk_source[i] == ip) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offer one word after a random gap and hold it until the block takes it.
  task automatic send_word(input psrl_pkg::in_word_t w);
    int unsigned         gap;
    psrl_pkg::out_word_t want_r;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 50) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    want_r = predict_result(w);
    pending_results.insert(pending_results.size(), want_r);
  endtask

  // Stop offering and wait until every owed result has been taken.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write rate_limit once the block has gone idle.
  task automatic write_limit(input logic [psrl_pkg::LIMIT_W-1:0] value);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    limit_now = value;
    n_cfg++;
  endtask

  // With limiting off, checks pass at the field extremes and a sweep still runs.
  task automatic test_limiting_disabled();
    write_limit('0);
    send_word(make_word(psrl_pkg::OP_CHECK, '0, '0));
    send_word(make_word(psrl_pkg::OP_CHECK, '1, '1));
    send_word(make_word(psrl_pkg::OP_SWEEP, $urandom, '0));
  endtask

  // Window restart at exactly one second, time wrap, and the stale boundary of a sweep.
  task automatic test_window_and_wrap();
    logic [psrl_pkg::IP_W-1:0] ip_a;
    ip_a = 32'h0A00_0001;
    write_limit(psrl_pkg::LIMIT_W'(2));
    send_word(make_word(psrl_pkg::OP_CHECK, ip_a, 32'd1000));
    send_word(make_word(psrl_pkg::OP_CHECK, ip_a, 32'd1500));
    send_word(make_word(psrl_pkg::OP_CHECK, ip_a, 32'd1999));
    send_word(make_word(psrl_pkg::OP_CHECK, ip_a, 32'd2000));
    send_word(make_word(psrl_pkg::OP_CHECK, '1, 32'hFFFF_FF00));
    send_word(make_word(psrl_pkg::OP_CHECK, '1, 32'h0000_0100));
    send_word(make_word(psrl_pkg::OP_CHECK, '1, 32'h0000_0101));
    send_word(make_word(psrl_pkg::OP_CHECK, '1, 32'h0000_02E8));
    send_word(make_word(psrl_pkg::OP_CHECK, '0, 32'h0000_02E8));
    // The tracker that started at 2000 is exactly 2000 ms old and survives.
    send_word(make_word(psrl_pkg::OP_SWEEP, $urandom, 32'd4000));
    write_limit('0);
    send_word(make_word(psrl_pkg::OP_CHECK, ip_a, 32'd4100));
    send_word(make_word(psrl_pkg::OP_SWEEP, $urandom, 32'd4001));
  endtask

  // A check while limiting is off must not advance the count of a tracker.
  task automatic test_disabled_keeps_trackers();
    logic [psrl_pkg::IP_W-1:0] ip_d;
    ip_d = $urandom;
    write_limit(psrl_pkg::LIMIT_W'(1));
    send_word(make_word(psrl_pkg::OP_CHECK, ip_d, 32'd5000));
    write_limit('0);
    send_word(make_word(psrl_pkg::OP_CHECK, ip_d, 32'd5100));
    write_limit(psrl_pkg::LIMIT_W'(1));
    send_word(make_word(psrl_pkg::OP_CHECK, ip_d, 32'd5200));
    write_limit(LIMIT_MAX);
    send_word(make_word(psrl_pkg::OP_CHECK, ip_d, 32'd5300));
  endtask

  // Fill every tracker, then an unknown source is refused unless limiting is off.
  task automatic test_table_full();
    logic [psrl_pkg::IP_W-1:0] ip;
    cur_ms = 32'h8000_0000;
    write_limit(LIMIT_MAX);
    send_word(make_word(psrl_pkg::OP_SWEEP, $urandom, cur_ms));
    while (trk_live < psrl_pkg::TABLE_ENTRIES) begin
      do ip = $urandom; while (ip_tracked(ip));
      send_word(make_word(psrl_pkg::OP_CHECK, ip, cur_ms));
    end
    do ip = $urandom; while (ip_tracked(ip));
    send_word(make_word(psrl_pkg::OP_CHECK, ip, cur_ms));
    write_limit('0);
    send_word(make_word(psrl_pkg::OP_CHECK, ip, cur_ms));
    write_limit(LIMIT_MAX);
    send_word(make_word(psrl_pkg::OP_CHECK,
                        trk_source[$urandom_range(psrl_pkg::TABLE_ENTRIES - 1)], cur_ms));
    send_word(make_word(psrl_pkg::OP_SWEEP, $urandom, cur_ms + 32'd2001));
  endtask

  // The receiver stops for a long stretch while words keep coming.
  task automatic test_output_backpressure();
    logic [psrl_pkg::IP_W-1:0] ip;
    ip = $urandom;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(psrl_pkg::LIMIT_W'(5));
    hold_request = HOLD_OFF;
    for (int n = 0; n < 16; n++) begin
      cur_ms += 32'd10;
      send_word(make_word(psrl_pkg::OP_CHECK, ip, cur_ms));
    end
  endtask

  // Mostly a small set of busy sources with advancing time; some sweeps and noise.
  task automatic test_random_traffic(input int unsigned words, input int unsigned send_pct,
                                     input int unsigned recv_pct,
                                     input logic [psrl_pkg::TIME_W-1:0] start_ms);
    logic [psrl_pkg::IP_W-1:0]    pool [POOL_SIZE];
    logic [psrl_pkg::LIMIT_W-1:0] lim;
    int unsigned                  roll;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    cur_ms = start_ms;
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = $urandom;
    for (int n = 0; n < words; n++) begin
      if (n % 55 == 0) begin
        case ($urandom_range(5))
          0:       lim = '0;
          1:       lim = psrl_pkg::LIMIT_W'(1);
          2:       lim = psrl_pkg::LIMIT_W'(2);
          3:       lim = psrl_pkg::LIMIT_W'($urandom_range(3, 12));
          4:       lim = LIMIT_MAX;
          default: lim = psrl_pkg::LIMIT_W'($urandom_range(1, 2 ** psrl_pkg::LIMIT_W - 1));
        endcase
        write_limit(lim);
      end
      if ($urandom_range(99) < 4) cur_ms += psrl_pkg::TIME_W'($urandom_range(1000, 2600));
      else cur_ms += psrl_pkg::TIME_W'($urandom_range(0, 40));
      roll = $urandom_range(99);
      if (roll < 8) begin
        send_word(make_word(psrl_pkg::OP_SWEEP, $urandom, cur_ms));
      end else if (roll < 14) begin
        send_word(make_word(psrl_pkg::OP_CHECK, $urandom, cur_ms));
      end else if (roll < 17) begin
        send_word(make_word(psrl_pkg::OP_CHECK, pool[$urandom_range(POOL_SIZE - 1)],
                            $urandom));
      end else begin
        send_word(make_word(psrl_pkg::OP_CHECK, pool[$urandom_range(POOL_SIZE - 1)],
                            cur_ms));
      end
    end
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation; watch for a hang.
  always @(posedge clk_i) begin : result_monitor
    psrl_pkg::out_word_t want;
    if (!rst_ni) begin
      stall_cycles = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result word %h arrived with nothing expected", out_word_o);
          err_count++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (out_word_o.allowed !== want.allowed) begin
            $error("allowed: expected %0d, got %0d", want.allowed, out_word_o.allowed);
            err_count++;
          end
          if (out_word_o.table_full_reject !== want.table_full_reject) begin
            $error("table_full_reject: expected %0d, got %0d",
                   want.table_full_reject, out_word_o.table_full_reject);
            err_count++;
          end
          if (out_word_o.entries_in_use !== want.entries_in_use) begin
            $error("entries_in_use: expected %0d, got %0d",
                   want.entries_in_use, out_word_o.entries_in_use);
            err_count++;
          end
          if (out_word_o.entries_removed !== want.entries_removed) begin
            $error("entries_removed: expected %0d, got %0d",
                   want.entries_removed, out_word_o.entries_removed);
            err_count++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    for (int i = 0; i < psrl_pkg::TABLE_ENTRIES; i++) trk_valid[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 16;
    recv_idle_pct = 74;
    test_limiting_disabled();
    test_window_and_wrap();
    test_disabled_keeps_trackers();
    test_table_full();
    test_random_traffic(340, 16, 74, cur_ms);
    test_random_traffic(340, 74, 16, 32'hFFFF_F000);
    test_output_backpressure();
    test_random_traffic(330, 0, 0, cur_ms);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d words (%0d sweeps, %0d trackers freed) under %0d rate_limit writes.",
             n_words, n_sweeps, n_removed, n_cfg);
    $display("Checks: %0d allowed, %0d over rate, %0d table-full rejects; peak %0d trackers.",
             n_allowed, n_limited, n_full, peak_live);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/psrl_pkg.sv
design/psrl_ram.sv
design/per_source_rate_limiter_unit.sv
sim/per_source_rate_limiter_unit_tb.sv
